@@ sv/lbss_pkg.sv @@
package lbss_pkg;

  // Field widths of the input and result words.
  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 24;
  localparam int SWEEP_W   = 32;
  localparam int BASE_W    = 16;
  localparam int BASE_FRAC = 12;

  // Growth factor register: reset value 1.5 and the value 1.0 in Q4.12.
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(6144);
  localparam logic [BASE_W-1:0] BASE_ONE   = BASE_W'(4096);

  // Three observables are tracked per bin.
  localparam int NUM_OBS   = 3;
  localparam int OBS_IDX_W = 2;

  // Accumulator and arithmetic widths.
  localparam int SUM_W    = SAMPLE_W + COUNT_W;
  localparam int MAG2_W   = 2 * SAMPLE_W;
  localparam int SQ_RAW_W = 2 * SAMPLE_W + COUNT_W;
  localparam int SQ_W     = (SQ_RAW_W > 64) ? 64 : SQ_RAW_W;
  localparam int DIFF_A_W = COUNT_W + SQ_W;
  localparam int DIFF_B_W = 2 * SUM_W;
  localparam int DIFF_W   = (DIFF_A_W > DIFF_B_W) ? DIFF_A_W : DIFF_B_W;
  localparam int ROOT_W   = (2 * SWEEP_W > MAG2_W) ? 2 * SWEEP_W : MAG2_W;

  // Queue depths.
  localparam int SNAP_DEPTH = 2;
  localparam int OUT_DEPTH  = 2;

  // Request codes.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic [SWEEP_W-1:0]         sweep_index;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic signed [SAMPLE_W-1:0] y_square_sample;
    logic signed [SAMPLE_W-1:0] dy_square_sample;
  } lbss_item_t;

  typedef struct packed {
    logic [SWEEP_W-1:0]         lo_sweep;
    logic [SWEEP_W-1:0]         bin_end;
    logic [SWEEP_W-1:0]         mid_sweep;
    logic [COUNT_W-1:0]         point_count;
    logic signed [SAMPLE_W-1:0] mean_y;
    logic [SAMPLE_W-1:0]        err_y;
    logic signed [SAMPLE_W-1:0] mean_y2;
    logic [SAMPLE_W-1:0]        err_y2;
    logic signed [SAMPLE_W-1:0] mean_dy2;
    logic [SAMPLE_W-1:0]        err_dy2;
  } lbss_result_t;

  // A closed bin as handed from the front end to the back end.
  typedef struct packed {
    logic [SWEEP_W-1:0]                lo;
    logic [SWEEP_W-1:0]                hi;
    logic [COUNT_W-1:0]                count;
    logic [NUM_OBS-1:0][SUM_W-1:0]     sum;
    logic [NUM_OBS-1:0][SQ_W-1:0]      sq;
  } lbss_snap_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_CHECK,
    FR_MUL,
    FR_STEP,
    FR_ACC
  } lbss_front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CENTER,
    BK_ISSUE,
    BK_WAIT,
    BK_PUSH
  } lbss_back_state_e;

  typedef enum logic [2:0] {
    OP_CTR_ROOT,
    OP_MEAN_DIV,
    OP_NQ_MUL,
    OP_SS_MUL,
    OP_DIV_N1,
    OP_DIV_N2,
    OP_DIV_NM1,
    OP_ERR_ROOT
  } lbss_op_e;

endpackage

@@ sv/lbss_queue.sv @@
module lbss_queue #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/lbss_front.sv @@
module lbss_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  lbss_pkg::lbss_item_t          item_i,
  output logic                          full_o,
  input  logic [lbss_pkg::BASE_W-1:0]   base_i,
  output lbss_pkg::lbss_snap_t          snap_o,
  output logic                          snap_push_o,
  input  logic                          snap_full_i
);
  import lbss_pkg::*;

  localparam int PROD_W = SWEEP_W + BASE_W;
  localparam int NXT_W  = PROD_W - BASE_FRAC + 1;
  localparam logic [SWEEP_W-1:0] SWEEP_MAX = {SWEEP_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  lbss_front_state_e   state_q, state_d;
  lbss_item_t          item_q, item_d;
  logic [SWEEP_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q [NUM_OBS];
  logic [SUM_W-1:0]    sum_d [NUM_OBS];
  logic [SQ_W-1:0]     sq_q [NUM_OBS];
  logic [SQ_W-1:0]     sq_d [NUM_OBS];
  logic [MAG2_W-1:0]   sqr_q [NUM_OBS];
  logic [MAG2_W-1:0]   sqr_d [NUM_OBS];
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [SAMPLE_W-1:0] smp [NUM_OBS];
  logic [SAMPLE_W-1:0] mag [NUM_OBS];
  logic [SWEEP_W-1:0]  sweep;
  logic [NXT_W-1:0]    nxt;
  logic [SQ_W:0]       sq_sum [NUM_OBS];

  assign full_o = (state_q != FR_IDLE);
  assign sweep  = item_q.sweep_index;
  assign smp[0] = item_q.y_sample;
  assign smp[1] = item_q.y_square_sample;
  assign smp[2] = item_q.dy_square_sample;

  // Snapshot of the open bin, pushed when it closes or is flushed.
  always_comb begin
    snap_o.lo    = lo_q;
    snap_o.hi    = hi_q;
    snap_o.count = cnt_q;
    for (int k = 0; k < NUM_OBS; k++) begin
      snap_o.sum[k] = sum_q[k];
      snap_o.sq[k]  = sq_q[k];
    end
  end

  // Magnitudes of the samples and their saturating square sums.
  always_comb begin
    for (int k = 0; k < NUM_OBS; k++) begin
      mag[k]    = smp[k][SAMPLE_W-1] ? (~smp[k] + 1'b1) : smp[k];
      sq_sum[k] = {1'b0, sq_q[k]} + (SQ_W + 1)'(sqr_q[k]);
    end
  end

  // Next upper edge from the registered product.
  always_comb begin
    nxt = {1'b0, prod_q[PROD_W-1:BASE_FRAC]} + 1'b1;
    if (nxt <= NXT_W'(hi_q)) begin
      nxt = NXT_W'(hi_q) + 1'b1;
    end
    if (nxt > NXT_W'(SWEEP_MAX)) begin
      nxt = NXT_W'(SWEEP_MAX);
    end
  end

  // Sequencer for one request.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    snap_push_o = 1'b0;
    for (int k = 0; k < NUM_OBS; k++) begin
      sum_d[k] = sum_q[k];
      sq_d[k]  = sq_q[k];
      sqr_d[k] = sqr_q[k];
    end
    case (state_q)
      FR_IDLE: begin
        if (push_i) begin
          item_d  = item_i;
          state_d = FR_CHECK;
        end
      end
      FR_CHECK: begin
        for (int k = 0; k < NUM_OBS; k++) begin
          sqr_d[k] = mag[k] * mag[k];
        end
        if (item_q.req_type == REQ_FLUSH) begin
          if (cnt_q == '0) begin
            state_d = FR_IDLE;
          end else if (!snap_full_i) begin
            snap_push_o = 1'b1;
            state_d     = FR_IDLE;
          end
        end else if (sweep > hi_q) begin
          if (cnt_q == '0 || !snap_full_i) begin
            snap_push_o = (cnt_q != '0);
            cnt_d       = '0;
            for (int k = 0; k < NUM_OBS; k++) begin
              sum_d[k] = '0;
              sq_d[k]  = '0;
            end
            if (base_i <= BASE_ONE) begin
              lo_d    = sweep - 1'b1;
              hi_d    = sweep;
              state_d = FR_ACC;
            end else begin
              state_d = FR_MUL;
            end
          end
        end else begin
          state_d = FR_ACC;
        end
      end
      FR_MUL: begin
        prod_d  = hi_q * base_i;
        state_d = FR_STEP;
      end
      FR_STEP: begin
        lo_d    = hi_q;
        hi_d    = nxt[SWEEP_W-1:0];
        state_d = (sweep > nxt[SWEEP_W-1:0]) ? FR_MUL : FR_ACC;
      end
      FR_ACC: begin
        if (cnt_q != COUNT_MAX) begin
          cnt_d = cnt_q + 1'b1;
          for (int k = 0; k < NUM_OBS; k++) begin
            sum_d[k] = sum_q[k] + {{(SUM_W - SAMPLE_W){smp[k][SAMPLE_W-1]}}, smp[k]};
            sq_d[k]  = sq_sum[k][SQ_W] ? {SQ_W{1'b1}} : sq_sum[k][SQ_W-1:0];
          end
        end
        state_d = FR_IDLE;
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      lo_q    <= SWEEP_W'(1);
      hi_q    <= SWEEP_W'(2);
      cnt_q   <= '0;
      for (int k = 0; k < NUM_OBS; k++) begin
        sum_q[k] <= '0;
        sq_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      cnt_q   <= cnt_d;
      for (int k = 0; k < NUM_OBS; k++) begin
        sum_q[k] <= sum_d[k];
        sq_q[k]  <= sq_d[k];
      end
    end
  end

  // Request word, squares and edge product.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    prod_q <= prod_d;
    for (int k = 0; k < NUM_OBS; k++) begin
      sqr_q[k] <= sqr_d[k];
    end
  end

  // A closed bin is only handed over when the queue has room.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_push_o |-> !snap_full_i) else $error("front pushed into full queue");

  // The bin edges stay strictly ordered.
  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q < hi_q) else $error("bin edges out of order");

  // Edge stepping only runs while the sweep is beyond the upper edge.
  a_step_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FR_STEP) |-> (sweep > hi_q)) else $error("needless edge step");

endmodule

@@ sv/lbss_divider.sv @@
module lbss_divider #(
  parameter int DVD_W = 80,
  parameter int DVS_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o,
  output logic [DVS_W-1:0] remainder_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] num_q;
  logic [DVS_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign quotient_o  = num_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

  // One restoring step: shift in the next dividend bit and try the divisor.
  assign trial = {rem_q, num_q[DVD_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(DVD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[DVD_W-2:0], fits};
      rem_q <= fits ? DVS_W'(trial - {1'b0, den_q}) : trial[DVS_W-1:0];
    end
  end

endmodule

@@ sv/lbss_isqrt.sv @@
module lbss_isqrt #(
  parameter int IN_W = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IN_W-1:0]   radicand_i,
  output logic              done_o,
  output logic [IN_W/2-1:0] root_o
);

  localparam int HALF_W = IN_W / 2;
  localparam int REM_W  = HALF_W + 2;
  localparam int CNT_W  = $clog2(HALF_W + 1);

  logic [IN_W-1:0]   rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [HALF_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [REM_W+1:0]  rem2;
  logic [REM_W+1:0]  trial;
  logic              fits;

  assign root_o = root_q;
  assign done_o = done_q;

  // One result bit per step: bring down two radicand bits, try 4*root+1.
  assign rem2  = {rem_q, rad_q[IN_W-1:IN_W-2]};
  assign trial = (REM_W + 2)'({root_q, 2'b01});
  assign fits  = (rem2 >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(HALF_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[IN_W-3:0], 2'b00};
      rem_q  <= fits ? REM_W'(rem2 - trial) : REM_W'(rem2);
      root_q <= {root_q[HALF_W-2:0], fits};
    end
  end

endmodule

@@ sv/lbss_back.sv @@
module lbss_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lbss_pkg::lbss_snap_t   snap_i,
  input  logic                   snap_empty_i,
  output logic                   snap_pop_o,
  output lbss_pkg::lbss_result_t res_o,
  output logic                   res_push_o,
  input  logic                   res_full_i
);
  import lbss_pkg::*;

  localparam int MCNT_W = $clog2(SUM_W + 1);

  lbss_back_state_e    state_q, state_d;
  lbss_op_e            op_q, op_d;
  logic [OBS_IDX_W-1:0] k_q, k_d;
  lbss_snap_t          snap_q, snap_d;
  logic [2*SWEEP_W-1:0] prod_q, prod_d;
  logic [SWEEP_W-1:0]  center_q, center_d;
  logic [SAMPLE_W-1:0] mean_q [NUM_OBS];
  logic [SAMPLE_W-1:0] mean_d [NUM_OBS];
  logic [SAMPLE_W-1:0] err_q [NUM_OBS];
  logic [SAMPLE_W-1:0] err_d [NUM_OBS];
  logic [DIFF_W-1:0]   nq_q, nq_d, work_q, work_d;
  logic [DIFF_W-1:0]   mul_a_q, mul_a_d, mul_acc_q, mul_acc_d;
  logic [SUM_W-1:0]    mul_b_q, mul_b_d;
  logic [MCNT_W-1:0]   mul_cnt_q, mul_cnt_d;

  logic [SUM_W-1:0]    sum_sel, mag_sel;
  logic                sum_neg;
  logic [SQ_W-1:0]     sq_sel;
  logic [COUNT_W-1:0]  n;
  logic [SAMPLE_W-1:0] ceil_lo;
  logic                err_sat;
  logic                last_obs;

  logic                div_start, div_done;
  logic [DIFF_W-1:0]   div_num, div_quot;
  logic [COUNT_W-1:0]  div_den, div_rem;
  logic                root_start, root_done;
  logic [ROOT_W-1:0]   root_in;
  logic [ROOT_W/2-1:0] root_out;

  lbss_divider #(
    .DVD_W (DIFF_W),
    .DVS_W (COUNT_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_num),
    .divisor_i   (div_den),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  lbss_isqrt #(
    .IN_W (ROOT_W)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (root_in),
    .done_o     (root_done),
    .root_o     (root_out)
  );

  // Operands of the observable being worked on.
  assign n        = snap_q.count;
  assign sum_sel  = snap_q.sum[k_q];
  assign sq_sel   = snap_q.sq[k_q];
  assign sum_neg  = sum_sel[SUM_W-1];
  assign mag_sel  = sum_neg ? (~sum_sel + 1'b1) : sum_sel;
  assign ceil_lo  = div_quot[SAMPLE_W-1:0] + SAMPLE_W'(div_rem != '0);
  assign err_sat  = |work_q[DIFF_W-1:MAG2_W];
  assign last_obs = (k_q == OBS_IDX_W'(NUM_OBS - 1));

  // Result word.
  always_comb begin
    res_o.lo_sweep    = snap_q.lo;
    res_o.bin_end     = snap_q.hi;
    res_o.mid_sweep   = center_q;
    res_o.point_count = snap_q.count;
    res_o.mean_y      = mean_q[0];
    res_o.err_y       = err_q[0];
    res_o.mean_y2     = mean_q[1];
    res_o.err_y2      = err_q[1];
    res_o.mean_dy2    = mean_q[2];
    res_o.err_dy2     = err_q[2];
  end

  // Sequencer over the operations of one closed bin.
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    k_d        = k_q;
    snap_d     = snap_q;
    prod_d     = prod_q;
    center_d   = center_q;
    nq_d       = nq_q;
    work_d     = work_q;
    mul_a_d    = mul_a_q;
    mul_b_d    = mul_b_q;
    mul_acc_d  = mul_acc_q;
    mul_cnt_d  = mul_cnt_q;
    snap_pop_o = 1'b0;
    res_push_o = 1'b0;
    div_start  = 1'b0;
    div_num    = work_q;
    div_den    = n;
    root_start = 1'b0;
    root_in    = ROOT_W'(prod_q);
    for (int j = 0; j < NUM_OBS; j++) begin
      mean_d[j] = mean_q[j];
      err_d[j]  = err_q[j];
    end
    case (state_q)
      BK_IDLE: begin
        if (!snap_empty_i) begin
          snap_pop_o = 1'b1;
          snap_d     = snap_i;
          state_d    = BK_CENTER;
        end
      end
      BK_CENTER: begin
        prod_d  = snap_q.lo * snap_q.hi;
        op_d    = OP_CTR_ROOT;
        k_d     = '0;
        state_d = BK_ISSUE;
      end
      BK_ISSUE: begin
        state_d = BK_WAIT;
        case (op_q)
          OP_CTR_ROOT: root_start = 1'b1;
          OP_MEAN_DIV: begin
            div_start = 1'b1;
            div_num   = DIFF_W'(mag_sel);
          end
          OP_NQ_MUL: begin
            mul_a_d   = DIFF_W'(sq_sel);
            mul_b_d   = SUM_W'(n);
            mul_acc_d = '0;
            mul_cnt_d = MCNT_W'(SUM_W);
          end
          OP_SS_MUL: begin
            mul_a_d   = DIFF_W'(mag_sel);
            mul_b_d   = mag_sel;
            mul_acc_d = '0;
            mul_cnt_d = MCNT_W'(SUM_W);
          end
          OP_DIV_N1, OP_DIV_N2: div_start = 1'b1;
          OP_DIV_NM1: begin
            div_start = 1'b1;
            div_den   = n - 1'b1;
          end
          OP_ERR_ROOT: begin
            root_start = 1'b1;
            root_in    = err_sat ? ROOT_W'({MAG2_W{1'b1}})
                                 : ROOT_W'(work_q[MAG2_W-1:0]);
          end
          default: state_d = BK_IDLE;
        endcase
      end
      BK_WAIT: begin
        case (op_q)
          OP_CTR_ROOT: begin
            if (root_done) begin
              center_d = root_out[SWEEP_W-1:0];
              op_d     = OP_MEAN_DIV;
              state_d  = BK_ISSUE;
            end
          end
          OP_MEAN_DIV: begin
            if (div_done) begin
              mean_d[k_q] = sum_neg ? (~ceil_lo + 1'b1) : div_quot[SAMPLE_W-1:0];
              if (n > COUNT_W'(1)) begin
                op_d    = OP_NQ_MUL;
                state_d = BK_ISSUE;
              end else begin
                err_d[k_q] = '0;
                op_d       = OP_MEAN_DIV;
                k_d        = k_q + 1'b1;
                state_d    = last_obs ? BK_PUSH : BK_ISSUE;
              end
            end
          end
          OP_NQ_MUL, OP_SS_MUL: begin
            if (mul_cnt_q != '0) begin
              mul_acc_d = mul_acc_q + (mul_b_q[0] ? mul_a_q : '0);
              mul_a_d   = {mul_a_q[DIFF_W-2:0], 1'b0};
              mul_b_d   = {1'b0, mul_b_q[SUM_W-1:1]};
              mul_cnt_d = mul_cnt_q - 1'b1;
            end else if (op_q == OP_NQ_MUL) begin
              nq_d    = mul_acc_q;
              op_d    = OP_SS_MUL;
              state_d = BK_ISSUE;
            end else begin
              work_d  = (nq_q >= mul_acc_q) ? (nq_q - mul_acc_q) : '0;
              op_d    = OP_DIV_N1;
              state_d = BK_ISSUE;
            end
          end
          OP_DIV_N1, OP_DIV_N2, OP_DIV_NM1: begin
            if (div_done) begin
              work_d  = div_quot;
              op_d    = (op_q == OP_DIV_N1) ? OP_DIV_N2 :
                        (op_q == OP_DIV_N2) ? OP_DIV_NM1 : OP_ERR_ROOT;
              state_d = BK_ISSUE;
            end
          end
          OP_ERR_ROOT: begin
            if (root_done) begin
              err_d[k_q] = root_out[SAMPLE_W-1:0];
              op_d       = OP_MEAN_DIV;
              k_d        = k_q + 1'b1;
              state_d    = last_obs ? BK_PUSH : BK_ISSUE;
            end
          end
          default: state_d = BK_IDLE;
        endcase
      end
      BK_PUSH: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      op_q      <= OP_CTR_ROOT;
      k_q       <= '0;
      mul_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      k_q       <= k_d;
      mul_cnt_q <= mul_cnt_d;
    end
  end

  // Working registers of the bin being finished.
  always_ff @(posedge clk_i) begin
    snap_q    <= snap_d;
    prod_q    <= prod_d;
    center_q  <= center_d;
    nq_q      <= nq_d;
    work_q    <= work_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    mul_acc_q <= mul_acc_d;
    for (int j = 0; j < NUM_OBS; j++) begin
      mean_q[j] <= mean_d[j];
      err_q[j]  <= err_d[j];
    end
  end

  // A result is only written when the output queue has room.
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("back pushed into full queue");

  // The divide by count minus one is only reached for two or more samples.
  a_nm1_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ISSUE && op_q == OP_DIV_NM1) |-> (n > COUNT_W'(1)))
    else $error("divide by zero count");

  // Unit completions only arrive while the sequencer waits for them.
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done || root_done) |-> (state_q == BK_WAIT))
    else $error("unit finished outside wait");

endmodule

@@ sv/log_binned_stream_statistics_core.sv @@
// Logarithmically binned running statistics of three observables. Each input
// word is a sample tagged with its sweep number, or a flush request; samples
// are summed into the open bin (start, end], starting with (1, 2], and a
// sample past the end closes the bin and steps the edges by the growth factor
// until it fits (a factor of at most 1.0 gives (sweep-1, sweep]). A closed
// nonempty bin, or a flush of a nonempty bin, yields one result word with
// the edges, the geometric center, the count and each observable's mean and
// standard error. A sample is checked, then takes a multiply and an update
// for every bin edge it steps past, then is summed; a flush is only checked.
// Closed bins wait in a two-entry queue; the back end finishes each with up
// to four 80-bit divides per observable in a one-bit-per-cycle divider.
// Growth_base may only be written while no request or result is in flight.
module log_binned_stream_statistics_core #(
  parameter int SNAP_DEPTH = lbss_pkg::SNAP_DEPTH,
  parameter int OUT_DEPTH  = lbss_pkg::OUT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  lbss_pkg::lbss_item_t          in_word_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output lbss_pkg::lbss_result_t        out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbss_pkg::BASE_W-1:0]   cfg_data_i
);
  import lbss_pkg::*;

  logic [BASE_W-1:0] growth_base_q;
  lbss_snap_t        snap_in, snap_out;
  logic              snap_push, snap_full, snap_pop, snap_empty;
  lbss_result_t      res;
  logic              res_push, res_full;
  logic              front_full;

  // Growth factor register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      growth_base_q <= BASE_RESET;
    end else if (cfg_valid_i) begin
      growth_base_q <= cfg_data_i;
    end
  end

  assign full = front_full;

  lbss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_word_i),
    .full_o      (front_full),
    .base_i      (growth_base_q),
    .snap_o      (snap_in),
    .snap_push_o (snap_push),
    .snap_full_i (snap_full)
  );

  lbss_queue #(
    .DEPTH (SNAP_DEPTH),
    .WIDTH ($bits(lbss_snap_t))
  ) u_snap_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .full_o  (snap_full),
    .pop_i   (snap_pop),
    .data_o  (snap_out),
    .empty_o (snap_empty)
  );

  lbss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_i       (snap_out),
    .snap_empty_i (snap_empty),
    .snap_pop_o   (snap_pop),
    .res_o        (res),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  lbss_queue #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(lbss_result_t))
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_word_o),
    .empty_o (empty)
  );

endmodule

@@ sim/log_binned_stream_statistics_core_tb.sv @@
module log_binned_stream_statistics_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbss_pkg::*;

  localparam int unsigned RUN_LIMIT = 4000000;
  localparam int unsigned SETTLE_CYCLES = 3000;
  localparam logic [63:0] SWEEP_TOP = (64'd1 << SWEEP_W) - 64'd1;
  localparam logic [63:0] COUNT_TOP = (64'd1 << COUNT_W) - 64'd1;

  // One queued word on its way in, with an optional hand-typed expectation.
  typedef struct {
    lbss_item_t   item;
    bit           typed;
    lbss_result_t res;
  } pending_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         push = 1'b0;
  lbss_item_t   in_word_i = '0;
  logic         full;
  logic         empty;
  logic         pop = 1'b0;
  lbss_result_t out_word_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [BASE_W-1:0] cfg_data_i = '0;

  log_binned_stream_statistics_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_word_i  (in_word_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the binning state.
  logic [BASE_W-1:0] base_sh;
  logic [63:0]       lo_sh, hi_sh, cnt_sh;
  logic signed [63:0] sum_sh [NUM_OBS];
  logic [63:0]       sq_sh [NUM_OBS];

  pending_word_t pending_q[$];
  lbss_result_t  bin_q[$];
  int unsigned   err_cnt = 0;
  int unsigned   cycle_cnt = 0;
  bit            steady = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] p;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      p = t * t;
      if (p <= {64'd0, x}) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] grow_edge(logic [63:0] e);
    logic [63:0] c;
    c = ((e * base_sh) >> BASE_FRAC) + 64'd1;
    if (c <= e) c = e + 64'd1;
    if (c > SWEEP_TOP) c = SWEEP_TOP;
    return c;
  endfunction

  // Mean (floor) and standard error of one observable in the open bin.
  function automatic void obs_stats(input int k, output logic [SAMPLE_W-1:0] mean,
                                    output logic [SAMPLE_W-1:0] err);
    logic [63:0]  n, mag, e;
    logic signed [63:0] m;
    logic [127:0] nq, ss, d;
    n = cnt_sh;
    mag = (sum_sh[k] < 0) ? 64'(-sum_sh[k]) : 64'(sum_sh[k]);
    if (sum_sh[k] >= 0) m = $signed(mag / n);
    else m = -$signed((mag + n - 64'd1) / n);
    mean = m[SAMPLE_W-1:0];
    err = '0;
    if (n > 64'd1) begin
      nq = {64'd0, n} * {64'd0, sq_sh[k]};
      ss = {64'd0, mag} * {64'd0, mag};
      d = (nq >= ss) ? nq - ss : '0;
      d = d / n;
      d = d / n;
      d = d / (n - 64'd1);
      e = int_sqrt((d[127:64] != 0) ? '1 : d[63:0]);
      if (e > 64'hFFFF) e = 64'hFFFF;
      err = e[SAMPLE_W-1:0];
    end
  endfunction

  function automatic lbss_result_t bin_summary();
    lbss_result_t r;
    logic [SAMPLE_W-1:0] mn, er;
    r.lo_sweep    = lo_sh[SWEEP_W-1:0];
    r.bin_end     = hi_sh[SWEEP_W-1:0];
    r.mid_sweep   = SWEEP_W'(int_sqrt(lo_sh * hi_sh));
    r.point_count = cnt_sh[COUNT_W-1:0];
    obs_stats(0, mn, er); r.mean_y = mn;   r.err_y = er;
    obs_stats(1, mn, er); r.mean_y2 = mn;  r.err_y2 = er;
    obs_stats(2, mn, er); r.mean_dy2 = mn; r.err_dy2 = er;
    return r;
  endfunction

  function automatic void clear_bin_sh();
    cnt_sh = '0;
    for (int k = 0; k < NUM_OBS; k++) begin
      sum_sh[k] = '0;
      sq_sh[k] = '0;
    end
  endfunction

  // Advances the shadow state by one word; returns 1 when a bin is emitted.
  function automatic bit bin_step(lbss_item_t it, output lbss_result_t r);
    logic [63:0] sw, p;
    logic signed [63:0] s [NUM_OBS];
    bit hit;
    hit = 1'b0;
    r = '0;
    if (it.req_type == REQ_FLUSH) begin
      if (cnt_sh == 0) return 1'b0;
      r = bin_summary();
      return 1'b1;
    end
    sw = {32'd0, it.sweep_index};
    if (sw > hi_sh) begin
      if (cnt_sh != 0) begin
        r = bin_summary();
        hit = 1'b1;
      end
      clear_bin_sh();
      if (base_sh <= BASE_ONE) begin
        lo_sh = sw - 64'd1;
        hi_sh = sw;
      end else begin
        while (sw > hi_sh) begin
          lo_sh = hi_sh;
          hi_sh = grow_edge(hi_sh);
        end
      end
    end
    if (cnt_sh < COUNT_TOP) begin
      s[0] = 64'(it.y_sample);
      s[1] = 64'(it.y_square_sample);
      s[2] = 64'(it.dy_square_sample);
      cnt_sh++;
      for (int k = 0; k < NUM_OBS; k++) begin
        p = 64'(s[k] * s[k]);
        sum_sh[k] += s[k];
        sq_sh[k] = (sq_sh[k] > ~p) ? '1 : sq_sh[k] + p;
      end
    end
    return hit;
  endfunction

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      err_cnt++;
    end
  endtask

  // Prediction at each accepted input word and the config register write.
  always @(posedge clk_i) begin
    pending_word_t pw;
    lbss_result_t  r;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cfg_valid_i && cfg_ready_o) base_sh = cfg_data_i;
      if (push && !full) begin
        pw = pending_q.pop_front();
        if (bin_step(pw.item, r)) bin_q.push_back(pw.typed ? pw.res : r);
      end
    end
  end

  // Checking of each accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    lbss_result_t e;
    if (rst_ni && pop && !empty) begin
      if (bin_q.size() == 0) begin
        $error("result word with nothing expected");
        err_cnt++;
      end else begin
        e = bin_q.pop_front();
        check_field("lo_sweep", 64'(e.lo_sweep), 64'(out_word_o.lo_sweep));
        check_field("bin_end", 64'(e.bin_end), 64'(out_word_o.bin_end));
        check_field("mid_sweep", 64'(e.mid_sweep), 64'(out_word_o.mid_sweep));
        check_field("point_count", 64'(e.point_count), 64'(out_word_o.point_count));
        check_field("mean_y", 64'(e.mean_y), 64'(out_word_o.mean_y));
        check_field("err_y", 64'(e.err_y), 64'(out_word_o.err_y));
        check_field("mean_y2", 64'(e.mean_y2), 64'(out_word_o.mean_y2));
        check_field("err_y2", 64'(e.err_y2), 64'(out_word_o.err_y2));
        check_field("mean_dy2", 64'(e.mean_dy2), 64'(out_word_o.mean_dy2));
        check_field("err_dy2", 64'(e.err_dy2), 64'(out_word_o.err_dy2));
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > RUN_LIMIT) begin
      $display("log_binned_stream_statistics_core_tb: done, errors");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(30, 400);
  endfunction

  // Result side: pop in random bursts with random pauses.
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      g = idle_len();
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  task automatic send_word(lbss_item_t it, bit typed, lbss_result_t res);
    pending_word_t pw;
    int unsigned g;
    pw.item = it;
    pw.typed = typed;
    pw.res = res;
    g = idle_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    pending_q.push_back(pw);
    push <= 1'b1;
    in_word_i <= it;
    do @(posedge clk_i); while (full);
  endtask

  // Lets the block drain, then writes the growth factor.
  task automatic write_base(logic [BASE_W-1:0] v);
    push <= 1'b0;
    wait (bin_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic lbss_item_t make_word(logic t, logic [31:0] sw, int y, int y2, int dy2);
    lbss_item_t it;
    it.req_type = t;
    it.sweep_index = sw;
    it.y_sample = SAMPLE_W'(y);
    it.y_square_sample = SAMPLE_W'(y2);
    it.dy_square_sample = SAMPLE_W'(dy2);
    return it;
  endfunction

  // Random word, mostly sweeps inside or just past the open bin.
  function automatic lbss_item_t random_word();
    lbss_item_t it;
    logic [63:0] sw, span;
    int unsigned r;
    it = '0;
    it.y_sample = SAMPLE_W'($urandom());
    it.y_square_sample = SAMPLE_W'($urandom());
    it.dy_square_sample = SAMPLE_W'($urandom());
    r = $urandom_range(0, 99);
    it.req_type = (r < 15) ? REQ_FLUSH : REQ_SAMPLE;
    if (r < 55) sw = 64'($urandom_range(0, hi_sh[31:0]));
    else if (r < 90) sw = hi_sh + 64'($urandom_range(1, 3));
    else begin
      span = (base_sh >= BASE_RESET) ? hi_sh * 64'd3 : 64'd40;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      sw = hi_sh + 64'($urandom_range(1, span[31:0]));
    end
    if (sw > SWEEP_TOP) sw = SWEEP_TOP;
    it.sweep_index = sw[31:0];
    return it;
  endfunction

  typedef struct {
    lbss_item_t   item;
    bit           typed;
    lbss_result_t res;
  } table_row_t;

  // Stimulus: directed table, random phases at several growth factors, then
  // edge saturation at the largest factor.
  initial begin
    table_row_t   rows[$];
    lbss_result_t first_bin;
    logic [BASE_W-1:0] bases[6] = '{16'd0, 16'd4096, 16'd4097, 16'd6144,
                                    16'd12288, 16'hFFFF};
    base_sh = BASE_RESET;
    lo_sh = 64'd1;
    hi_sh = 64'd2;
    clear_bin_sh();

    first_bin = '{lo_sweep: 1, bin_end: 2, mid_sweep: 1, point_count: 1,
                  mean_y: 256, err_y: 0, mean_y2: -32768, err_y2: 0,
                  mean_dy2: 32767, err_dy2: 0};
    // Flush on empty bin, one sample, and a repeated flush of the same bin.
    rows.push_back('{make_word(REQ_FLUSH, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_word(REQ_SAMPLE, 2, 256, -32768, 32767), 0, '0});
    rows.push_back('{make_word(REQ_FLUSH, 0, 0, 0, 0), 1, first_bin});
    rows.push_back('{make_word(REQ_FLUSH, 32'hFFFF_FFFF, -1, -1, -1), 1, first_bin});
    // Sweeps at and below the lower edge land in the open bin.
    rows.push_back('{make_word(REQ_SAMPLE, 0, -32768, 32767, 0), 0, '0});
    rows.push_back('{make_word(REQ_SAMPLE, 1, 32767, -32768, -32768), 0, '0});
    rows.push_back('{make_word(REQ_SAMPLE, 2, -1, 1, 32767), 0, '0});
    // Closing the bin, then skipping several empty bins.
    rows.push_back('{make_word(REQ_SAMPLE, 3, 100, -100, 5), 0, '0});
    rows.push_back('{make_word(REQ_SAMPLE, 4, -7, 7, -5), 0, '0});
    rows.push_back('{make_word(REQ_SAMPLE, 100, 1, 2, 3), 0, '0});
    rows.push_back('{make_word(REQ_SAMPLE, 100, -32768, -32768, -32768), 0, '0});
    rows.push_back('{make_word(REQ_FLUSH, 12345, 9, 9, 9), 0, '0});
    rows.push_back('{make_word(REQ_SAMPLE, 1000, 32767, 32767, 32767), 0, '0});
    rows.push_back('{make_word(REQ_SAMPLE, 1000, 32767, 32767, 32767), 0, '0});
    rows.push_back('{make_word(REQ_SAMPLE, 1001, 0, 0, 0), 0, '0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].item, rows[i].typed, rows[i].res);

    foreach (bases[b]) begin
      write_base(bases[b]);
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(0, 49) == 0) steady = ~steady;
        send_word(random_word(), 1'b0, '0);
      end
    end

    // The top sweep drives the edges into saturation; nothing can close after.
    send_word(make_word(REQ_SAMPLE, 32'hFFFF_FFFF, 5, -5, 32767), 1'b0, '0);
    send_word(make_word(REQ_SAMPLE, 32'hFFFF_FFFF, -5, 5, -32768), 1'b0, '0);
    send_word(make_word(REQ_SAMPLE, 32'hFFFF_FFFE, 0, 0, 0), 1'b0, '0);
    send_word(make_word(REQ_FLUSH, 0, 0, 0, 0), 1'b0, '0);
    push <= 1'b0;

    wait (bin_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bin_q.size() != 0) begin
      $error("%0d expected result words never arrived", bin_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("log_binned_stream_statistics_core_tb: done, clean");
    end else begin
      $display("log_binned_stream_statistics_core_tb: done, errors");
    end
    $finish;
  end

endmodule
